// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the ownership table RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/etot_pkg.sv -----
// Package for the epoch tagged ownership table: types, codes, constants.
// Used by all modules of the block.
package etot_pkg;
  localparam int TableEntriesDef = 16;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_BEGIN  = 3'd2,
    REQ_RECORD = 3'd3,
    REQ_ENDED  = 3'd4,
    REQ_SLOTOF = 3'd5
  } req_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] peer_key;
    logic [63:0] task_tag;
    logic [63:0] range_epoch;
    logic        wants_workers;
  } in_item_t;

  typedef struct packed {
    logic        result_valid;
    logic [63:0] out_key;
    logic [63:0] out_task;
    logic [63:0] out_epoch;
    logic        last_of_run;
    logic        status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_EMIT, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic exec;      // perform single-result operation, build result
    logic scan_init; // bump epoch, start walk
    logic scan_step; // select next smallest candidate
    logic emit;      // build range-start result from selection
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_begin;
    logic more;      // further candidates remain after this one
  } stat_t;
endpackage

// ----- rtl/etot_datapath.sv -----
// Datapath of the ownership table: key/slot stores, matching, sorted walk.
// Depends on etot_pkg and assert_macros.svh.
`include "assert_macros.svh"
module etot_datapath
  import etot_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  ctrl_t     ctrl,
  output stat_t     stat,
  output out_item_t out_item
);
  localparam int N = TABLE_ENTRIES;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]  known_valid;
  logic [63:0]   known_key [N];
  logic [N-1:0]  slot_valid;
  logic [63:0]   slot_key [N];
  logic [63:0]   slot_task [N];
  logic [63:0]   slot_epoch [N];
  logic [63:0]   current_epoch;
  in_item_t      req;
  out_item_t     res;
  out_item_t     exec_res;

  // walk state: candidates still to emit, and the index of the selected entry
  logic [N-1:0]  pend;
  logic [IW-1:0] sel;
  logic          sel_ok;

  logic [N-1:0]  km, sm, kfree, sfree, kslot;
  logic [IW-1:0] sfi, sfreei, kfreei, slot_idx;
  logic          khit, shit, kfull, sfull, end_ok;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      km[i] = known_valid[i] && known_key[i] == req.peer_key;
      sm[i] = slot_valid[i] && slot_key[i] == req.peer_key;
      kfree[i] = !known_valid[i];
      sfree[i] = !slot_valid[i];
    end
    sfi = '0; kfreei = '0; sfreei = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (sm[i]) sfi = IW'(i);
      if (kfree[i]) kfreei = IW'(i);
      if (sfree[i]) sfreei = IW'(i);
    end
    khit = |km;
    shit = |sm;
    kfull = ~|kfree;
    sfull = ~|sfree;
    slot_idx = shit ? sfi : sfreei;
    end_ok = shit && slot_task[sfi] == req.task_tag && slot_epoch[sfi] == req.range_epoch;
  end

  // result of a single-result operation
  always_comb begin
    exec_res = '0;
    exec_res.last_of_run = 1'b1;
    unique case (req.req_type)
      REQ_ADD: if (!khit && kfull) exec_res.status = 1'b1;
      REQ_RECORD: if (!shit && sfull) exec_res.status = 1'b1;
      REQ_ENDED: begin
        if (end_ok && req.range_epoch != current_epoch && req.wants_workers && khit) begin
          exec_res.result_valid = 1'b1;
          exec_res.out_key = req.peer_key;
        end
      end
      REQ_SLOTOF: begin
        if (shit) begin
          exec_res.result_valid = 1'b1;
          exec_res.out_key = req.peer_key;
          exec_res.out_task = slot_task[sfi];
          exec_res.out_epoch = slot_epoch[sfi];
        end
      end
      default: ;
    endcase
  end

  // known entries that have a slot (computed at scan start)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      kslot[i] = 1'b0;
      for (int j = 0; j < N; j++)
        if (slot_valid[j] && slot_key[j] == known_key[i]) kslot[i] = 1'b1;
    end
  end

  // pick the smallest pending key: entry i wins if no pending j beats it
  logic [N-1:0]  win;
  logic [IW-1:0] wini;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      win[i] = pend[i];
      for (int j = 0; j < N; j++)
        if (pend[j] && j != i &&
            (known_key[j] < known_key[i] || (known_key[j] == known_key[i] && j < i)))
          win[i] = 1'b0;
    end
    wini = '0;
    for (int i = N - 1; i >= 0; i--)
      if (win[i]) wini = IW'(i);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) req <= in_item;
    if (rst) begin
      known_valid <= '0;
      slot_valid <= '0;
      current_epoch <= '0;
      pend <= '0;
      sel_ok <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        res <= exec_res;
        unique case (req.req_type)
          REQ_CLEAR: known_valid <= '0;
          REQ_ADD: begin
            if (!khit && !kfull) begin
              known_valid[kfreei] <= 1'b1;
              known_key[kfreei] <= req.peer_key;
            end
          end
          REQ_RECORD: begin
            if (shit || !sfull) begin
              slot_valid[slot_idx] <= 1'b1;
              slot_key[slot_idx] <= req.peer_key;
              slot_task[slot_idx] <= req.task_tag;
              slot_epoch[slot_idx] <= req.range_epoch;
            end
          end
          REQ_ENDED: if (end_ok) slot_valid[sfi] <= 1'b0;
          default: ;
        endcase
      end
      if (ctrl.scan_init) begin
        current_epoch <= current_epoch + 64'd1;
        pend <= known_valid & ~kslot;
      end
      if (ctrl.scan_step) begin
        sel_ok <= |pend;
        sel <= wini;
        pend <= pend & ~win;
      end
      if (ctrl.emit) begin
        res.result_valid <= sel_ok;
        res.out_key <= sel_ok ? known_key[sel] : 64'd0;
        res.out_task <= '0;
        res.out_epoch <= current_epoch;
        res.last_of_run <= ~|pend;
        res.status <= 1'b0;
      end
    end
  end

  assign stat.is_begin = req.req_type == REQ_BEGIN;
  assign stat.more = |pend;
  assign out_item = res;

  `ASSERT_CLK(a_pend_known, clk, rst, (pend & ~known_valid) == '0, "pending non-known entry")
  `ASSERT_CLK(a_epoch_step, clk, rst, $past(ctrl.scan_init) |-> current_epoch == $past(current_epoch) + 64'd1, "epoch step")
  `ASSERT_CLK(a_win_onehot, clk, rst, $onehot0(win), "multiple winners")
endmodule

// ----- rtl/etot_ctrl.sv -----
// Controller of the ownership table: sequences one transaction at a time.
// Depends on etot_pkg and assert_macros.svh.
`include "assert_macros.svh"
module etot_ctrl
  import etot_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_begin) begin
          ctrl.scan_init = 1'b1;
          state_next = ST_SCAN;
        end else begin
          ctrl.exec = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_SCAN: begin
        ctrl.scan_step = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        ctrl.emit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = stat.more ? ST_SCAN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_no_overlap, clk, rst, !(in_ready && out_valid), "accept while holding result")
  `ASSERT_CLK(a_load_exec, clk, rst, ctrl.load |=> state == ST_EXEC, "load not followed by exec")
  `ASSERT_CLK(a_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule

// ----- rtl/epoch_tagged_ownership_table_unit.sv -----
// Epoch tagged ownership table: known key set plus owner slots, sorted walk.
// Top level; depends on etot_pkg, etot_ctrl and etot_datapath.
//
// Input channel in_valid/in_ready carries in_item_t transactions (request
// type, peer key, task tag, epoch, wants_workers). Output channel
// out_valid/out_ready carries out_item_t results; last_of_run marks the
// final result of a transaction. One transaction is handled at a time.
// Operations other than a range start load the request, execute it into the
// output register and show the result, then return to idle once it is taken.
// A range start emits one result per key with no slot, in ascending order
// (a single invalid result if there is none); after the epoch is bumped, each
// result is selected, built and handed over in turn by the controller sequence.
// Reset (synchronous, rst) empties the known set and slot table and sets
// the epoch to zero. When the receiver stalls the result is held in the
// output register and no new transaction is accepted.
module epoch_tagged_ownership_table_unit
  import etot_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  ctrl_t ctrl;
  stat_t stat;

  etot_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .ctrl
  );

  etot_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst, .in_item, .ctrl, .stat, .out_item
  );
endmodule

// ----- bench/tb_epoch_tagged_ownership_table_unit.sv -----
// Self-checking bench for the epoch tagged ownership table unit.
// Depends on etot_pkg and epoch_tagged_ownership_table_unit; predicts results in a class.
module tb_epoch_tagged_ownership_table_unit;
  import etot_pkg::*;

  localparam int Entries = TableEntriesDef;

  class ownership_scoreboard;
    bit          known_v[Entries];
    logic [63:0] known_k[Entries];
    bit          slot_v[Entries];
    logic [63:0] slot_k[Entries];
    logic [63:0] slot_t[Entries];
    logic [63:0] slot_e[Entries];
    logic [63:0] epoch_now;
    out_item_t   pending[$];
    int          errors;
    int          results_seen;

    function int known_index(logic [63:0] k);
      for (int i = 0; i < Entries; i++)
        if (known_v[i] && known_k[i] == k) return i;
      return -1;
    endfunction

    function int slot_index(logic [63:0] k);
      for (int i = 0; i < Entries; i++)
        if (slot_v[i] && slot_k[i] == k) return i;
      return -1;
    endfunction

    function void push(bit v, logic [63:0] k, logic [63:0] t, logic [63:0] e,
                       bit last, bit st);
      out_item_t r;
      r.result_valid = v;
      r.out_key = k;
      r.out_task = t;
      r.out_epoch = e;
      r.last_of_run = last;
      r.status = st;
      pending.insert(pending.size(), r);
    endfunction

    function void note_request(in_item_t it);
      logic [63:0] cand[$];
      int i;
      bit st;
      bit hand;
      st = 0;
      hand = 0;
      case (it.req_type)
        REQ_CLEAR: begin
          for (i = 0; i < Entries; i++) known_v[i] = 0;
          push(0, 0, 0, 0, 1, 0);
        end
        REQ_ADD: begin
          if (known_index(it.peer_key) < 0) begin
            for (i = 0; i < Entries; i++) if (!known_v[i]) break;
            if (i < Entries) begin
              known_v[i] = 1;
              known_k[i] = it.peer_key;
            end else st = 1;
          end
          push(0, 0, 0, 0, 1, st);
        end
        REQ_BEGIN: begin
          epoch_now = epoch_now + 64'd1;
          for (i = 0; i < Entries; i++)
            if (known_v[i] && slot_index(known_k[i]) < 0) cand.insert(cand.size(), known_k[i]);
          cand.sort();
          if (cand.size() == 0) push(0, 0, 0, epoch_now, 1, 0);
          foreach (cand[j]) push(1, cand[j], 0, epoch_now, j == cand.size() - 1, 0);
        end
        REQ_RECORD: begin
          i = slot_index(it.peer_key);
          if (i < 0) begin
            for (i = 0; i < Entries; i++) if (!slot_v[i]) break;
            if (i >= Entries) i = -1;
          end
          if (i >= 0) begin
            slot_v[i] = 1;
            slot_k[i] = it.peer_key;
            slot_t[i] = it.task_tag;
            slot_e[i] = it.range_epoch;
          end else st = 1;
          push(0, 0, 0, 0, 1, st);
        end
        REQ_ENDED: begin
          i = slot_index(it.peer_key);
          if (i >= 0 && slot_t[i] == it.task_tag && slot_e[i] == it.range_epoch) begin
            slot_v[i] = 0;
            if (it.range_epoch != epoch_now && it.wants_workers &&
                known_index(it.peer_key) >= 0) hand = 1;
          end
          if (hand) push(1, it.peer_key, 0, 0, 1, 0);
          else push(0, 0, 0, 0, 1, 0);
        end
        REQ_SLOTOF: begin
          i = slot_index(it.peer_key);
          if (i >= 0) push(1, it.peer_key, slot_t[i], slot_e[i], 1, 0);
          else push(0, 0, 0, 0, 1, 0);
        end
        default: push(0, 0, 0, 0, 1, 0);
      endcase
    endfunction

    task check_result(out_item_t got);
      out_item_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      exp = pending.pop_front();
      if (got.result_valid !== exp.result_valid)
        report_mismatch("result_valid", got.result_valid, exp.result_valid);
      if (got.out_key !== exp.out_key) report_mismatch("out_key", got.out_key, exp.out_key);
      if (got.out_task !== exp.out_task) report_mismatch("out_task", got.out_task, exp.out_task);
      if (got.out_epoch !== exp.out_epoch)
        report_mismatch("out_epoch", got.out_epoch, exp.out_epoch);
      if (got.last_of_run !== exp.last_of_run)
        report_mismatch("last_of_run", got.last_of_run, exp.last_of_run);
      if (got.status !== exp.status) report_mismatch("status", got.status, exp.status);
    endtask

    task report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
      errors++;
      $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, exp);
    endtask
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_item;

  ownership_scoreboard board;
  logic [63:0] key_pool[8];
  bit          hold_off = 0;
  bit          stim_done = 0;
  int          idle_cycles = 0;

  epoch_tagged_ownership_table_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #10 clk = ~clk;

  function int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(req_e op, logic [63:0] k, logic [63:0] t, logic [63:0] e,
                              bit w, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_item.req_type <= op;
    in_item.peer_key <= k;
    in_item.task_tag <= t;
    in_item.range_epoch <= e;
    in_item.wants_workers <= w;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_request(in_item);
    @(negedge clk);
  endtask

  // pick keys mostly from a small pool so that operations meet each other
  function logic [63:0] pick_key();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // sender side ------------------------------------------------------------
  initial begin
    logic [63:0] k;
    int i;
    int sel;
    int s;
    board = new();
    board.epoch_now = 0;
    foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom};
    key_pool[0] = 64'h0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty walk, extremes, full tables, mismatches, odd codes
    send_request(REQ_BEGIN, 0, 0, 0, 0, 0);
    send_request(REQ_SLOTOF, 64'h5, 0, 0, 0, 0);
    send_request(REQ_ADD, 64'h0, 0, 0, 0, 0);
    send_request(REQ_ADD, '1, 0, 0, 0, 0);
    send_request(REQ_ADD, '1, 0, 0, 0, 0);
    for (i = 0; i < 15; i++) send_request(REQ_ADD, {$urandom, $urandom}, 0, 0, 0, 0);
    send_request(REQ_BEGIN, 0, 0, 0, 0, 0);
    send_request(REQ_RECORD, '1, '1, '1, 1, 0);
    send_request(REQ_SLOTOF, '1, 0, 0, 0, 0);
    send_request(REQ_ENDED, '1, '1, 64'h7, 1, 0);
    send_request(REQ_ENDED, '1, '1, '1, 1, 0);
    send_request(REQ_RECORD, 64'h0, 64'h3, 64'h2, 0, 0);
    send_request(REQ_ENDED, 64'h0, 64'h3, 64'h2, 1, 0);
    for (i = 0; i < 17; i++)
      send_request(REQ_RECORD, {$urandom, $urandom}, 64'(i), 64'(i), 0, 0);
    send_request(REQ_BEGIN, 0, 0, 0, 0, 0);
    send_request(req_e'(3'd6), '1, '1, '1, 1, 0);
    send_request(req_e'(3'd7), 0, 0, 0, 0, 0);
    send_request(REQ_CLEAR, 0, 0, 0, 0, 0);

    // random: mostly add/begin/record/ended cycles over the key pool
    for (i = 0; i < 400; i++) begin
      if (i == 200) hold_off = 1;
      sel = $urandom_range(0, 99);
      k = pick_key();
      if (sel < 4) send_request(REQ_CLEAR, {$urandom, $urandom}, 0, 0, 0, 1);
      else if (sel < 28) send_request(REQ_ADD, k, {$urandom, $urandom}, 0, 0, 1);
      else if (sel < 42) send_request(REQ_BEGIN, k, 0, 0, 1'($urandom), 1);
      else if (sel < 62)
        send_request(REQ_RECORD, k, 64'($urandom_range(0, 3)),
                     $urandom_range(0, 2) == 0 ? {$urandom, $urandom}
                       : board.epoch_now - 64'($urandom_range(0, 1)),
                     1'($urandom), 1);
      else if (sel < 84) begin
        // slot contents are known to the predictor; hit them often
        s = $urandom_range(0, Entries - 1);
        if (board.slot_v[s] && $urandom_range(0, 3) != 0)
          send_request(REQ_ENDED, board.slot_k[s], board.slot_t[s], board.slot_e[s],
                       1'($urandom), 1);
        else
          send_request(REQ_ENDED, k, 64'($urandom_range(0, 3)), board.epoch_now,
                       1'($urandom), 1);
      end
      else if (sel < 97) send_request(REQ_SLOTOF, k, 0, 0, 0, 1);
      else send_request(req_e'($urandom_range(6, 7)), k, {$urandom, $urandom},
                        {$urandom, $urandom}, 1'($urandom), 1);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // receiver side ----------------------------------------------------------
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      @(negedge clk);
      if (hold_off) begin
        // hold back long enough that the sender stalls behind full results
        out_ready <= 0;
        repeat (120) @(negedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) out_ready <= 1;
      else begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_item);
  end

  // watchdog and end of run ------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("epoch_tagged_ownership_table_unit verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("epoch_tagged_ownership_table_unit verification clean");
    else
      $display("epoch_tagged_ownership_table_unit verification failed");
    $finish;
  end
endmodule
